### src/pgge_pkg.sv
`default_nettype none
package pgge_pkg;

    // sequence value width, code word width, bit counter width
    localparam int VALUE_BITS  = 32;
    localparam int WORD_BITS   = 32;
    localparam int OFFSET_BITS = 48;
    localparam int PHASE_BITS  = 16;
    localparam int LEN_BITS    = $clog2(VALUE_BITS + 1);
    localparam int FILL_BITS   = $clog2(WORD_BITS);

    // results one value can cause, and the result queue behind the coder
    localparam int MAX_RESULTS = 3;
    localparam int SLOT_BITS   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                   run_end;
        logic                   zero_gap_error;
        logic [OFFSET_BITS-1:0] bit_offset;
        logic [WORD_BITS-1:0]   payload;
        logic                   kind;
    } result_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]          count;
        result_t [MAX_RESULTS-1:0]     slot;
    } batch_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase;
        logic [VALUE_BITS-1:0]  prev;
        logic [WORD_BITS-1:0]   pack;
        logic [FILL_BITS-1:0]   fill;
        logic [OFFSET_BITS-1:0] total;
    } coder_state_t;

    // number of significant bits of a value
    function automatic logic [LEN_BITS-1:0] bit_length(input logic [VALUE_BITS-1:0] v);
        logic [LEN_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (v[i]) begin
                n = LEN_BITS'(i + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### src/pgge_coder.sv
`default_nettype none
module pgge_coder
    import pgge_pkg::*;
(
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic                  in_last,
    input  wire logic [WORD_BITS-1:0]  modulus,
    input  wire logic [PHASE_BITS-1:0] interval,
    input  wire coder_state_t          st,
    output coder_state_t               st_next,
    output batch_t                     batch
);

    localparam int WIN_BITS = 3 * WORD_BITS;
    localparam int SH_BITS  = $clog2(WIN_BITS + 1);

    logic [VALUE_BITS-1:0]  gap;
    logic [LEN_BITS-1:0]    glen;
    logic [SH_BITS-1:0]     clen;
    logic [SH_BITS-1:0]     sum_fill;
    logic [SH_BITS-1:0]     shamt;
    logic [WIN_BITS-1:0]    win;
    logic [WORD_BITS-1:0]   code_pack;
    logic [1:0]             nwords;
    logic                   is_sample;
    logic                   is_zero;
    logic                   coding;
    logic [WORD_BITS-1:0]   post_pack;
    logic [FILL_BITS-1:0]   post_fill;
    logic [OFFSET_BITS-1:0] total_next;
    logic                   flush_v;
    logic [PHASE_BITS:0]    phase_inc;
    result_t                lead;
    result_t                flush_res;
    result_t                word_res [2];
    logic [SLOT_BITS-1:0]   n;

    // gap with wrap by modulus, and gamma code length 2L-1
    always_comb begin
        gap  = in_value - st.prev + ((in_value < st.prev) ? modulus[VALUE_BITS-1:0] : '0);
        glen = bit_length(gap);
        clen = SH_BITS'({glen, 1'b0}) - SH_BITS'(1);
    end

    // place the code right below the pending bits in a three-word window
    always_comb begin
        sum_fill = SH_BITS'(st.fill) + clen;
        shamt    = SH_BITS'(WIN_BITS) - sum_fill;
        win      = {st.pack, {(2 * WORD_BITS){1'b0}}} | (WIN_BITS'(gap) << shamt);
        nwords   = sum_fill[FILL_BITS+1:FILL_BITS];
        case (nwords)
            2'd0:    code_pack = win[3*WORD_BITS-1:2*WORD_BITS];
            2'd1:    code_pack = win[2*WORD_BITS-1:WORD_BITS];
            default: code_pack = win[WORD_BITS-1:0];
        endcase
    end

    // select what this value does
    always_comb begin
        is_sample  = (st.phase == '0);
        is_zero    = !is_sample && (gap == '0);
        coding     = !is_sample && !is_zero;
        post_pack  = coding ? code_pack : st.pack;
        post_fill  = coding ? sum_fill[FILL_BITS-1:0] : st.fill;
        total_next = coding ? (st.total + OFFSET_BITS'(clen)) : st.total;
        flush_v    = in_last && (post_fill != '0);
    end

    // result list: lead result or completed words, then the flushed word
    always_comb begin
        lead.run_end        = 1'b0;
        lead.zero_gap_error = is_zero;
        lead.bit_offset     = is_sample ? st.total : '0;
        lead.payload        = is_sample ? WORD_BITS'(in_value) : '0;
        lead.kind           = is_sample ? KIND_SAMPLE : KIND_WORD;

        flush_res.run_end        = 1'b0;
        flush_res.zero_gap_error = 1'b0;
        flush_res.bit_offset     = '0;
        flush_res.payload        = post_pack;
        flush_res.kind           = KIND_WORD;

        word_res[0]         = flush_res;
        word_res[0].payload = win[3*WORD_BITS-1:2*WORD_BITS];
        word_res[1]         = flush_res;
        word_res[1].payload = win[2*WORD_BITS-1:WORD_BITS];

        batch.slot = '0;
        if (coding) begin
            batch.slot[0] = word_res[0];
            batch.slot[1] = word_res[1];
            n = SLOT_BITS'(nwords);
        end else begin
            batch.slot[0] = lead;
            n = SLOT_BITS'(1);
        end
        if (flush_v) begin
            batch.slot[n[1:0]] = flush_res;
            n = n + SLOT_BITS'(1);
        end
        if (n != '0) begin
            batch.slot[n[1:0] - 2'd1].run_end = 1'b1;
        end
        batch.count = n;
    end

    // next coder state, cleared after the last value of a sequence
    always_comb begin
        phase_inc = {1'b0, st.phase} + (PHASE_BITS + 1)'(1);
        if (in_last) begin
            st_next = '0;
        end else begin
            st_next.phase = (phase_inc >= {1'b0, interval}) ? '0 : phase_inc[PHASE_BITS-1:0];
            st_next.prev  = in_value;
            st_next.pack  = post_pack;
            st_next.fill  = post_fill;
            st_next.total = total_next;
        end
    end

endmodule
`default_nettype wire

### src/pgge_result_queue.sv
`default_nettype none
module pgge_result_queue
    import pgge_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire batch_t  batch,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    result_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]    wr_ptr_reg;
    logic [QPTR_BITS-1:0]    rd_ptr_reg;
    logic [QCNT_BITS-1:0]    count_reg;
    logic [QPTR_BITS-1:0]    wr_ptr_next;
    logic [QPTR_BITS-1:0]    rd_ptr_next;
    logic [QCNT_BITS-1:0]    count_next;
    logic                    pop;
    logic [QCNT_BITS-1:0]    push_n;

    // room for a full batch whatever happens on the output side
    assign room      = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and count update
    always_comb begin
        push_n      = push ? QCNT_BITS'(batch.count) : '0;
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push_n);
        rd_ptr_next = pop ? (rd_ptr_reg + QPTR_BITS'(1)) : rd_ptr_reg;
        count_next  = count_reg + push_n - (pop ? QCNT_BITS'(1) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // batch entries land in consecutive slots
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (push && (SLOT_BITS'(i) < batch.count)) begin
                entry_reg[wr_ptr_reg + QPTR_BITS'(i)] <= batch.slot[i];
            end
        end
    end

endmodule
`default_nettype wire

### src/phi_gap_gamma_encoder.sv
// phi_gap_gamma_encoder: gamma coder for a stream of sequence values
// input channel s_*: one value per word, s_tlast marks the last value of
// a sequence; the partial code word is flushed and coder state returns
// to its reset value afterwards (configuration is kept).
// output channel m_*: sample words (value and bit count so far), zero-gap
// reports and packed 32-bit code words; m_tlast closes the results of
// one input value.
// configuration: cfg_we writes modulus (index 0) or sample interval
// (index 1); the user must write only while the block is idle, since
// the block itself does not enforce it.
// an accepted value is held in the input register and coded into a
// four-entry result queue once the queue has room for a full batch.
// throughput: one value per cycle while each value yields at most one
// result and m_tready stays high; the result queue drains one word per
// cycle, so a value that yields two or three words stalls the input.
// when the receiver stalls, the queue and then the input register fill
// and s_tready drops; no word is lost.
// reset (aresetn low, synchronous) empties both stages, clears the coder
// state and restores modulus 0xffffffff and sample interval 64.
`default_nettype none
module phi_gap_gamma_encoder
    import pgge_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: seq_value[31:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,
    // m_tdata: payload[31:0], bit_offset[79:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,
    // m_tuser: kind[0], zero_gap_error[1]
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    logic                  in_valid_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic                  in_last_reg;
    logic [WORD_BITS-1:0]  modulus_reg;
    logic [PHASE_BITS-1:0] interval_reg;
    coder_state_t          st_reg;
    coder_state_t          st_next;
    batch_t                batch;
    logic                  room;
    logic                  fire;
    result_t               out_res;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_value_reg <= s_tdata[VALUE_BITS-1:0];
            in_last_reg  <= s_tlast;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= '1;
            interval_reg <= PHASE_BITS'(64);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODULUS:  modulus_reg  <= cfg_wdata;
                REG_INTERVAL: interval_reg <= cfg_wdata[PHASE_BITS-1:0];
                default:      modulus_reg  <= modulus_reg;
            endcase
        end
    end

    // coder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    pgge_coder u_coder (
        .in_value (in_value_reg),
        .in_last  (in_last_reg),
        .modulus  (modulus_reg),
        .interval (interval_reg),
        .st       (st_reg),
        .st_next  (st_next),
        .batch    (batch)
    );

    pgge_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .batch     (batch),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // output word packing
    assign m_tdata = {out_res.bit_offset, out_res.payload};
    assign m_tuser = {out_res.zero_gap_error, out_res.kind};
    assign m_tlast = out_res.run_end;

endmodule
`default_nettype wire
